// ===== rtl/pai_pkg.sv =====
package pai_pkg;

  // Table size default
  localparam int MaxObjectsDef = 4;

  // Field widths
  localparam int CoordW = 12;
  localparam int CountW = 3;
  localparam int IndexW = 2;
  localparam int SqW    = 25;   // dx*dx + dy*dy, at most 2*4095^2
  localparam int RootW  = 13;   // isqrt of SqW bits
  localparam int QuoW   = 13;   // drop quotient, below 2*full
  localparam int DivCntW = 4;

  localparam int InTdataW  = 56;
  localparam int OutTdataW = 16;

  // Register reset values
  localparam logic [CountW-1:0] ObjectCountRst  = '0;
  localparam logic [CoordW-1:0] DeadbandLowRst  = 12'd1900;
  localparam logic [CoordW-1:0] DeadbandHighRst = 12'd2050;
  localparam logic [CoordW-1:0] CenterValueRst  = 12'd2048;
  localparam logic [CoordW-1:0] ActDistRst      = 12'd1000;
  localparam logic [CoordW-1:0] FullIntRst      = 12'd3000;

  // First trial bit of the square root, highest power of four below 2^SqW
  localparam logic [SqW-1:0] RootBitInit = 25'h100_0000;

  // Register indexes on the config port
  typedef enum logic [2:0] {
    CFG_OBJECT_COUNT  = 3'd0,
    CFG_DEADBAND_LOW  = 3'd1,
    CFG_DEADBAND_HIGH = 3'd2,
    CFG_CENTER_VALUE  = 3'd3,
    CFG_ACT_DISTANCE  = 3'd4,
    CFG_FULL_INTENSITY = 3'd5
  } cfg_index_t;

  // Input word kind (tuser)
  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_CALC,
    S_OUT
  } walk_state_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_SQX,
    C_SQY,
    C_ROOT,
    C_SCALE,
    C_DIV,
    C_FIN
  } calc_state_t;

  typedef struct packed {
    logic              start;
    logic [CoordW-1:0] dx;
    logic [CoordW-1:0] dy;
  } calc_req_t;

  typedef struct packed {
    logic            done;
    logic [QuoW-1:0] drop;
  } calc_rsp_t;

endpackage

// ===== rtl/proximity_alert_intensity.sv =====
// Channel   Dir  Word contents (low bit up)
// s_axis    in   tuser: mode; tdata: object_index, object_x, object_y, probe_x, probe_y
// m_axis    out  tdata: intensity (one word per query, none per load)
// cfg       in   cfg_index selects register, cfg_data written when cfg_wr_en is high
//
// A load writes one table entry. A query walks the counted entries and stops early
// on an exact hit; each entry in range goes through the shared root/divide unit
// (one root bit, one quotient bit per cycle). Reset clears control and config
// registers; the object table is not cleared. s_axis_tready is high only while no
// query is in flight; a finished result sits in the output register so the next
// word is taken while it waits.
module proximity_alert_intensity #(
  parameter int MAX_OBJECTS = pai_pkg::MaxObjectsDef
) (
  input  logic                            clk,
  input  logic                            rst,
  // config write port
  input  logic                            cfg_wr_en,
  input  logic [2:0]                      cfg_index,
  input  logic [pai_pkg::CoordW-1:0]      cfg_data,
  // input words
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [1:0] object_index, [13:2] object_x, [25:14] object_y,
  // [37:26] probe_x, [49:38] probe_y, rest zero
  input  logic [pai_pkg::InTdataW-1:0]    s_axis_tdata,
  // [0] mode
  input  logic                            s_axis_tuser,
  // result words
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [11:0] intensity, rest zero
  output logic [pai_pkg::OutTdataW-1:0]   m_axis_tdata
);

  localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int EW = 2 * pai_pkg::CoordW;

  // config registers
  logic [pai_pkg::CountW-1:0] object_count;
  logic [pai_pkg::CoordW-1:0] deadband_low;
  logic [pai_pkg::CoordW-1:0] deadband_high;
  logic [pai_pkg::CoordW-1:0] center_value;
  logic [pai_pkg::CoordW-1:0] activation_distance;
  logic [pai_pkg::CoordW-1:0] full_intensity;

  always_ff @(posedge clk) begin
    if (rst) begin
      object_count        <= pai_pkg::ObjectCountRst;
      deadband_low        <= pai_pkg::DeadbandLowRst;
      deadband_high       <= pai_pkg::DeadbandHighRst;
      center_value        <= pai_pkg::CenterValueRst;
      activation_distance <= pai_pkg::ActDistRst;
      full_intensity      <= pai_pkg::FullIntRst;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pai_pkg::CFG_OBJECT_COUNT:   object_count <= cfg_data[pai_pkg::CountW-1:0];
        pai_pkg::CFG_DEADBAND_LOW:   deadband_low <= cfg_data;
        pai_pkg::CFG_DEADBAND_HIGH:  deadband_high <= cfg_data;
        pai_pkg::CFG_CENTER_VALUE:   center_value <= cfg_data;
        pai_pkg::CFG_ACT_DISTANCE:   activation_distance <= cfg_data;
        pai_pkg::CFG_FULL_INTENSITY: full_intensity <= cfg_data;
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // input word unpack
  logic                       in_acc;
  logic [pai_pkg::IndexW-1:0] in_index;
  logic [pai_pkg::CoordW-1:0] in_ox, in_oy, in_px, in_py;
  logic [pai_pkg::CoordW-1:0] snap_x, snap_y;
  logic [pai_pkg::CountW-1:0] lim_in;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_index = s_axis_tdata[1:0];
  assign in_ox    = s_axis_tdata[13:2];
  assign in_oy    = s_axis_tdata[25:14];
  assign in_px    = s_axis_tdata[37:26];
  assign in_py    = s_axis_tdata[49:38];

  // dead band: strictly inside snaps to center
  assign snap_x = (in_px > deadband_low && in_px < deadband_high) ? center_value : in_px;
  assign snap_y = (in_py > deadband_low && in_py < deadband_high) ? center_value : in_py;

  // entries walked: count clipped to table size
  assign lim_in = (int'(object_count) < MAX_OBJECTS) ? object_count
                                                     : pai_pkg::CountW'(MAX_OBJECTS);

  // walk state
  pai_pkg::walk_state_t state, state_next;

  logic [pai_pkg::CoordW-1:0] px, py;
  logic [pai_pkg::CountW-1:0] idx, lim;
  logic [pai_pkg::CoordW-1:0] best;
  logic [pai_pkg::CoordW-1:0] intensity;

  // object table, one synchronous read port
  logic [EW-1:0] mem [MAX_OBJECTS];
  logic [EW-1:0] rd_data;
  logic          mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) mem[AW'(in_index)] <= {in_oy, in_ox};
    rd_data <= mem[AW'(idx)];
  end

  // per-entry test on the word read last cycle
  logic [pai_pkg::CoordW-1:0] ox, oy, dx, dy;
  logic                       hit, in_range, last;

  assign ox       = rd_data[pai_pkg::CoordW-1:0];
  assign oy       = rd_data[EW-1:pai_pkg::CoordW];
  assign dx       = (ox > px) ? ox - px : px - ox;
  assign dy       = (oy > py) ? oy - py : py - oy;
  assign hit      = (dx == '0) && (dy == '0);
  assign in_range = (activation_distance != '0) &&
                    (dx <= activation_distance) && (dy <= activation_distance);
  assign last     = (pai_pkg::CountW'(idx + 1'b1) == lim);

  // root / divide unit
  pai_pkg::calc_req_t req;
  pai_pkg::calc_rsp_t rsp;

  pai_calc u_calc (
    .clk  (clk),
    .rst  (rst),
    .act  (activation_distance),
    .full (full_intensity),
    .req  (req),
    .rsp  (rsp)
  );

  logic                       cand_ok;
  logic [pai_pkg::CoordW-1:0] cand;

  // drop below full gives a positive value; otherwise the entry adds nothing
  assign cand_ok = rsp.drop < {1'b0, full_intensity};
  assign cand    = full_intensity - rsp.drop[pai_pkg::CoordW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pai_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pai_pkg::S_IDLE: begin
        if (in_acc && s_axis_tuser == pai_pkg::MODE_QUERY) begin
          state_next = (lim_in == '0) ? pai_pkg::S_OUT : pai_pkg::S_READ;
        end
      end
      pai_pkg::S_READ: state_next = pai_pkg::S_EVAL;
      pai_pkg::S_EVAL: begin
        if (hit) begin
          state_next = pai_pkg::S_OUT;       // exact collision ends the walk
        end else if (in_range) begin
          state_next = pai_pkg::S_CALC;
        end else begin
          state_next = last ? pai_pkg::S_OUT : pai_pkg::S_READ;
        end
      end
      pai_pkg::S_CALC: begin
        if (rsp.done) state_next = last ? pai_pkg::S_OUT : pai_pkg::S_READ;
      end
      pai_pkg::S_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = pai_pkg::S_IDLE;
      end
      default: state_next = pai_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == pai_pkg::S_IDLE);
    mem_we        = in_acc && (s_axis_tuser == pai_pkg::MODE_LOAD) &&
                    (int'(in_index) < MAX_OBJECTS);
    req.start     = (state == pai_pkg::S_EVAL) && !hit && in_range;
    req.dx        = dx;
    req.dy        = dy;
  end

  // walk datapath
  always_ff @(posedge clk) begin
    case (state)
      pai_pkg::S_IDLE: begin
        if (in_acc && s_axis_tuser == pai_pkg::MODE_QUERY) begin
          px   <= snap_x;
          py   <= snap_y;
          idx  <= '0;
          lim  <= lim_in;
          best <= '0;
        end
      end
      pai_pkg::S_EVAL: begin
        if (hit) begin
          best <= full_intensity;
        end else if (!in_range) begin
          idx <= idx + 1'b1;
        end
      end
      pai_pkg::S_CALC: begin
        if (rsp.done) begin
          if (cand_ok && cand > best) best <= cand;
          idx <= idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == pai_pkg::S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pai_pkg::S_OUT && (!m_axis_tvalid || m_axis_tready)) intensity <= best;
  end

  assign m_axis_tdata = {{(pai_pkg::OutTdataW-pai_pkg::CoordW){1'b0}}, intensity};

`ifndef SYNTHESIS
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    state == pai_pkg::S_EVAL |-> $past(state) == pai_pkg::S_READ)
    else $error("entry evaluated without a read the cycle before");

  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> state == pai_pkg::S_CALC)
    else $error("calc result with nobody waiting");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    state == pai_pkg::S_READ |-> idx < lim)
    else $error("walk read past the counted entries");
`endif

endmodule

// ===== rtl/pai_calc.sv =====
// Drop term for one object: floor(isqrt(dx^2+dy^2)) * full / act.
// One shared 13x12 multiplier, one root bit and one quotient bit per cycle.
module pai_calc (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pai_pkg::CoordW-1:0]   act,
  input  logic [pai_pkg::CoordW-1:0]   full,
  input  pai_pkg::calc_req_t           req,
  output pai_pkg::calc_rsp_t           rsp
);

  pai_pkg::calc_state_t state, state_next;

  logic [pai_pkg::CoordW-1:0]  dx_r;
  logic [pai_pkg::CoordW-1:0]  dy_r;
  logic [pai_pkg::SqW-1:0]     acc;
  logic [pai_pkg::SqW-1:0]     res;
  logic [pai_pkg::SqW-1:0]     bitv;
  logic [pai_pkg::SqW-1:0]     rem;
  logic [pai_pkg::SqW-1:0]     dvsr;
  logic [pai_pkg::QuoW-1:0]    quo;
  logic [pai_pkg::DivCntW-1:0] cnt;

  logic [pai_pkg::RootW-1:0]   mul_a;
  logic [pai_pkg::CoordW-1:0]  mul_b;
  logic [pai_pkg::SqW-1:0]     prod;
  logic [pai_pkg::SqW:0]       trial;
  logic                        take_root;
  logic                        ge;

  assign prod      = {{(pai_pkg::SqW-pai_pkg::RootW){1'b0}}, mul_a}
                   * {{(pai_pkg::SqW-pai_pkg::CoordW){1'b0}}, mul_b};
  assign trial     = {1'b0, res} + {1'b0, bitv};
  assign take_root = {1'b0, acc} >= trial;
  assign ge        = rem >= dvsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pai_pkg::C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pai_pkg::C_IDLE:  if (req.start) state_next = pai_pkg::C_SQX;
      pai_pkg::C_SQX:   state_next = pai_pkg::C_SQY;
      pai_pkg::C_SQY:   state_next = pai_pkg::C_ROOT;
      pai_pkg::C_ROOT:  if (bitv[0]) state_next = pai_pkg::C_SCALE;
      pai_pkg::C_SCALE: state_next = pai_pkg::C_DIV;
      pai_pkg::C_DIV:   if (cnt == '0) state_next = pai_pkg::C_FIN;
      pai_pkg::C_FIN:   state_next = pai_pkg::C_IDLE;
      default:          state_next = pai_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state == pai_pkg::C_FIN);
    rsp.drop = quo;
    case (state)
      pai_pkg::C_SQX: begin
        mul_a = {1'b0, dx_r};
        mul_b = dx_r;
      end
      pai_pkg::C_SQY: begin
        mul_a = {1'b0, dy_r};
        mul_b = dy_r;
      end
      default: begin
        mul_a = res[pai_pkg::RootW-1:0];
        mul_b = full;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      pai_pkg::C_IDLE: begin
        if (req.start) begin
          dx_r <= req.dx;
          dy_r <= req.dy;
        end
      end
      pai_pkg::C_SQX: acc <= prod;
      pai_pkg::C_SQY: begin
        acc  <= acc + prod;
        res  <= '0;
        bitv <= pai_pkg::RootBitInit;
      end
      pai_pkg::C_ROOT: begin
        // bitwise square root, one result bit per cycle
        if (take_root) begin
          acc <= acc - trial[pai_pkg::SqW-1:0];
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
      end
      pai_pkg::C_SCALE: begin
        rem  <= prod;
        dvsr <= {1'b0, act, {(pai_pkg::QuoW-1){1'b0}}};
        quo  <= '0;
        cnt  <= pai_pkg::DivCntW'(pai_pkg::QuoW - 1);
      end
      pai_pkg::C_DIV: begin
        // restoring divide; quotient fits QuoW bits since dist <= 1.42*act
        if (ge) rem <= rem - dvsr;
        quo  <= {quo[pai_pkg::QuoW-2:0], ge};
        dvsr <= dvsr >> 1;
        cnt  <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == pai_pkg::C_IDLE)
    else $error("calc started while busy");

  a_root_bit: assert property (@(posedge clk) disable iff (rst)
    state == pai_pkg::C_ROOT |-> $onehot(bitv))
    else $error("root trial bit lost");

  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    state == pai_pkg::C_DIV |-> cnt <= pai_pkg::DivCntW'(pai_pkg::QuoW - 1))
    else $error("divide step count out of range");
`endif

endmodule

// ===== tb/proximity_alert_intensity_test.sv =====
`timescale 1ns / 1ps

module proximity_alert_intensity_test;
  import pai_pkg::*;

  // Worst query: every object in range, plus some slack
  localparam int QueryCycles = 2 + 32 * MaxObjectsDef + 30;
  localparam int CycleLimit = 1_500_000;
  localparam int RandomPhases = 6;
  localparam int WordsPerPhase = 272;

  // Directed script: either a register write or one input word
  typedef enum logic {
    ROW_REG,
    ROW_WORD
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    cfg_index_t        reg_sel;
    mode_t             mode;
    logic [IndexW-1:0] idx;
    logic [CoordW-1:0] x;       // register value, object or probe X
    logic [CoordW-1:0] y;       // object or probe Y
    logic              has_lit; // expected intensity typed in
    logic [CoordW-1:0] lit;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [2:0]           cfg_index = '0;
  logic [CoordW-1:0]    cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // [1:0] object_index, [13:2] object_x, [25:14] object_y,
  // [37:26] probe_x, [49:38] probe_y, rest zero
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  // [0] mode
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [11:0] intensity, rest zero
  logic [OutTdataW-1:0] m_axis_tdata;

  // Shadow of the register file and the object table
  logic [CountW-1:0] sh_count = ObjectCountRst;
  logic [CoordW-1:0] sh_db_low = DeadbandLowRst;
  logic [CoordW-1:0] sh_db_high = DeadbandHighRst;
  logic [CoordW-1:0] sh_center = CenterValueRst;
  logic [CoordW-1:0] sh_act = ActDistRst;
  logic [CoordW-1:0] sh_full = FullIntRst;
  logic [CoordW-1:0] obj_x [MaxObjectsDef];
  logic [CoordW-1:0] obj_y [MaxObjectsDef];

  logic [CoordW-1:0] expected_intensity [$];
  script_row_t       script [$];
  int                snd_gap_pct = 0;
  int                rcv_stall_pct = 0;
  int                mismatches = 0;
  int unsigned       cycle_count = 0;

  proximity_alert_intensity u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Intensity prediction
  // ---------------------------------------------------------------------------

  // floor(sqrt(v)) by setting root bits from the top down
  function automatic int unsigned floor_sqrt(input int unsigned v);
    int unsigned root;
    int unsigned trial;
    root = 0;
    for (int b = 12; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Coordinates strictly inside the dead band collapse onto the center value
  function automatic logic [CoordW-1:0] snap_coord(input logic [CoordW-1:0] p);
    return (p > sh_db_low && p < sh_db_high) ? sh_center : p;
  endfunction

  function automatic logic [CoordW-1:0] predict_intensity(input logic [CoordW-1:0] raw_x,
                                                          input logic [CoordW-1:0] raw_y);
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    int unsigned       dx;
    int unsigned       dy;
    int unsigned       root_len;
    int unsigned       drop;
    int unsigned       best;
    int unsigned       walk;
    logic              hit;
    px = snap_coord(raw_x);
    py = snap_coord(raw_y);
    best = 0;
    hit = 1'b0;
    // counts past the table size walk the whole table
    walk = (sh_count > MaxObjectsDef) ? MaxObjectsDef : 32'(sh_count);
    for (int i = 0; i < walk && !hit; i++) begin
      dx = 32'((obj_x[i] > px) ? obj_x[i] - px : px - obj_x[i]);
      dy = 32'((obj_y[i] > py) ? obj_y[i] - py : py - obj_y[i]);
      if (dx == 0 && dy == 0) begin
        // exact collision: full intensity, walk stops here
        best = 32'(sh_full);
        hit = 1'b1;
      end else if (sh_act != 0 && dx <= sh_act && dy <= sh_act) begin
        root_len = floor_sqrt(dx * dx + dy * dy);
        drop = root_len * sh_full / sh_act;
        // a drop at or past full would go negative; it never raises best
        if (drop < sh_full && sh_full - drop > best) best = sh_full - drop;
      end
    end
    return best[CoordW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  function automatic logic [InTdataW-1:0] pack_word(input logic [IndexW-1:0] idx,
                                                    input logic [CoordW-1:0] ox,
                                                    input logic [CoordW-1:0] oy,
                                                    input logic [CoordW-1:0] px,
                                                    input logic [CoordW-1:0] py);
    return {6'd0, py, px, oy, ox, idx};
  endfunction

  // Send one word; the fields a word does not use carry random bits
  task automatic send_word(input mode_t m, input logic [IndexW-1:0] idx,
                           input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                           input logic has_lit, input logic [CoordW-1:0] lit);
    logic [CoordW-1:0] fill_x;
    logic [CoordW-1:0] fill_y;
    fill_x = CoordW'($urandom);
    fill_y = CoordW'($urandom);
    cfg_wr_en <= 1'b0;
    while ($urandom_range(99) < snd_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= m;
    s_axis_tdata <= (m == MODE_LOAD) ? pack_word(idx, x, y, fill_x, fill_y)
                                     : pack_word(idx, fill_x, fill_y, x, y);
    do @(posedge clk); while (!s_axis_tready);
    if (m == MODE_LOAD) begin
      obj_x[idx] = x;
      obj_y[idx] = y;
    end else begin
      expected_intensity.push_back(has_lit ? lit : predict_intensity(x, y));
    end
  endtask

  // Drop valid, wait out every pending result and a full query after that,
  // since a trailing load leaves nothing to wait on
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    while (expected_intensity.size() != 0) @(posedge clk);
    repeat (QueryCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t sel, input logic [CoordW-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_data <= v;
    @(posedge clk);
    case (sel)
      CFG_OBJECT_COUNT:   sh_count = v[CountW-1:0];
      CFG_DEADBAND_LOW:   sh_db_low = v;
      CFG_DEADBAND_HIGH:  sh_db_high = v;
      CFG_CENTER_VALUE:   sh_center = v;
      CFG_ACT_DISTANCE:   sh_act = v;
      CFG_FULL_INTENSITY: sh_full = v;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Directed script helpers
  // ---------------------------------------------------------------------------

  function automatic void add_reg(input cfg_index_t sel, input logic [CoordW-1:0] v);
    script_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_sel = sel;
    r.x = v;
    script.push_back(r);
  endfunction

  function automatic void add_load(input logic [IndexW-1:0] idx,
                                   input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
    script_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.mode = MODE_LOAD;
    r.idx = idx;
    r.x = x;
    r.y = y;
    script.push_back(r);
  endfunction

  // has_lit = 0: the predictor supplies the expected intensity
  function automatic void add_query(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                                    input logic has_lit, input logic [CoordW-1:0] lit);
    script_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.mode = MODE_QUERY;
    r.idx = IndexW'($urandom);
    r.x = x;
    r.y = y;
    r.has_lit = has_lit;
    r.lit = lit;
    script.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Random stimulus
  // ---------------------------------------------------------------------------

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  // New settings for a phase, extremes favored
  task automatic random_config();
    int unsigned roll;
    int          lo;
    int          hi;
    roll = $urandom_range(99);
    if (roll < 15) write_reg(CFG_OBJECT_COUNT, 12'd0);
    else if (roll < 30) write_reg(CFG_OBJECT_COUNT, CoordW'($urandom_range(7, 5)));
    else write_reg(CFG_OBJECT_COUNT, CoordW'($urandom_range(4, 1)));

    roll = $urandom_range(99);
    if (roll < 10) begin
      lo = int'(DeadbandLowRst);
      hi = int'(DeadbandHighRst);
    end else if (roll < 20) begin
      lo = 0;
      hi = 4095;
    end else if (roll < 30) begin
      // inverted band, nothing snaps
      lo = int'($urandom_range(4095));
      hi = int'($urandom_range(lo));
    end else begin
      lo = int'($urandom_range(4095));
      hi = clamp_coord(lo + int'($urandom_range(400)));
    end
    write_reg(CFG_DEADBAND_LOW, lo[CoordW-1:0]);
    write_reg(CFG_DEADBAND_HIGH, hi[CoordW-1:0]);

    roll = $urandom_range(99);
    if (roll < 10) write_reg(CFG_CENTER_VALUE, 12'd0);
    else if (roll < 20) write_reg(CFG_CENTER_VALUE, 12'd4095);
    else write_reg(CFG_CENTER_VALUE, CoordW'($urandom));

    roll = $urandom_range(99);
    if (roll < 10) write_reg(CFG_ACT_DISTANCE, 12'd0);
    else if (roll < 20) write_reg(CFG_ACT_DISTANCE, 12'd4095);
    else if (roll < 50) write_reg(CFG_ACT_DISTANCE, CoordW'($urandom_range(64, 1)));
    else write_reg(CFG_ACT_DISTANCE, CoordW'($urandom_range(4095, 1)));

    roll = $urandom_range(99);
    if (roll < 10) write_reg(CFG_FULL_INTENSITY, 12'd0);
    else if (roll < 20) write_reg(CFG_FULL_INTENSITY, 12'd4095);
    else write_reg(CFG_FULL_INTENSITY, CoordW'($urandom));
  endtask

  // Mostly queries aimed at stored objects so the distance path gets exercised
  task automatic random_word();
    int unsigned roll;
    int unsigned k;
    int          span;
    int          px;
    int          py;
    roll = $urandom_range(99);
    if ($urandom_range(99) < 30) begin
      if (roll < 10) begin
        px = int'($urandom_range(1)) * 4095;
        py = int'($urandom_range(1)) * 4095;
      end else if (roll < 40) begin
        // around the usual dead band
        px = int'($urandom_range(2150, 1800));
        py = int'($urandom_range(2150, 1800));
      end else begin
        px = int'($urandom_range(4095));
        py = int'($urandom_range(4095));
      end
      send_word(MODE_LOAD, IndexW'($urandom), px[CoordW-1:0], py[CoordW-1:0], 1'b0, '0);
    end else begin
      k = $urandom_range(MaxObjectsDef - 1);
      span = int'(sh_act) + 2;
      if (roll < 15) begin
        px = int'(obj_x[k]);
        py = int'(obj_y[k]);
      end else if (roll < 65) begin
        px = clamp_coord(int'(obj_x[k]) + int'($urandom_range(2 * span)) - span);
        py = clamp_coord(int'(obj_y[k]) + int'($urandom_range(2 * span)) - span);
      end else if (roll < 80) begin
        px = int'($urandom_range(32'(sh_db_high), 32'(sh_db_low)));
        py = int'($urandom_range(32'(sh_db_high), 32'(sh_db_low)));
      end else begin
        px = int'($urandom_range(4095));
        py = int'($urandom_range(4095));
      end
      send_word(MODE_QUERY, IndexW'($urandom), px[CoordW-1:0], py[CoordW-1:0], 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker; the receiver stall is redrawn every cycle
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_intensity.size() == 0) begin
        $display("%0t: unexpected result word, intensity %0d", $time, m_axis_tdata[11:0]);
        mismatches++;
      end else if (m_axis_tdata[CoordW-1:0] !== expected_intensity[0]) begin
        $display("%0t: intensity expected %0d, got %0d", $time,
                 expected_intensity[0], m_axis_tdata[CoordW-1:0]);
        mismatches++;
        void'(expected_intensity.pop_front());
      end else begin
        void'(expected_intensity.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic after_word;

    // Reset config: count 0, nothing is walked yet
    add_query(12'd0, 12'd0, 1'b1, 12'd0);
    // Fill the whole table before any query walks it
    add_load(2'd0, 12'd0, 12'd0);
    add_load(2'd1, 12'd4095, 12'd4095);
    add_load(2'd2, 12'd2048, 12'd2048);
    add_load(2'd3, 12'd1000, 12'd3000);
    add_reg(CFG_OBJECT_COUNT, 12'd4);
    add_query(12'd0, 12'd0, 1'b1, 12'd3000);       // collision at the origin
    add_query(12'd4095, 12'd4095, 1'b1, 12'd3000); // collision at the far corner
    add_query(12'd1950, 12'd2000, 1'b1, 12'd3000); // both snap onto entry 2
    add_query(12'd1900, 12'd2050, 1'b0, '0);       // band edges do not snap
    add_query(12'd1901, 12'd2049, 1'b1, 12'd3000); // just inside the band
    add_query(12'd0, 12'd3000, 1'b0, '0);          // drop equals full
    add_query(12'd500, 12'd500, 1'b0, '0);
    add_reg(CFG_ACT_DISTANCE, 12'd1);
    add_reg(CFG_FULL_INTENSITY, 12'd4095);
    add_query(12'd1, 12'd0, 1'b0, '0);             // one step away, drop is full
    add_query(12'd4095, 12'd4095, 1'b1, 12'd4095);
    add_reg(CFG_ACT_DISTANCE, 12'd4095);
    add_reg(CFG_FULL_INTENSITY, 12'd0);
    add_query(12'd10, 12'd10, 1'b0, '0);           // zero full intensity
    add_reg(CFG_ACT_DISTANCE, 12'd0);
    add_reg(CFG_FULL_INTENSITY, 12'd4095);
    add_query(12'd5, 12'd5, 1'b0, '0);             // zero distance, no hit
    add_query(12'd1000, 12'd3000, 1'b1, 12'd4095); // only collisions count
    add_reg(CFG_OBJECT_COUNT, 12'd7);              // past the table size
    add_reg(CFG_ACT_DISTANCE, 12'd4095);
    add_reg(CFG_DEADBAND_LOW, 12'd0);
    add_reg(CFG_DEADBAND_HIGH, 12'd4095);
    add_reg(CFG_CENTER_VALUE, 12'd0);
    add_query(12'd100, 12'd100, 1'b1, 12'd4095);   // snaps onto the origin
    add_query(12'd0, 12'd4095, 1'b0, '0);          // coordinates on the band edges
    add_reg(CFG_DEADBAND_LOW, 12'd4095);
    add_reg(CFG_DEADBAND_HIGH, 12'd0);
    add_reg(CFG_CENTER_VALUE, 12'd4095);
    add_query(12'd2048, 12'd2048, 1'b1, 12'd4095); // empty band, no snap
    add_reg(CFG_OBJECT_COUNT, 12'd1);
    add_query(12'd4095, 12'd4095, 1'b0, '0);       // diagonal beyond reach

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: sender gaps, receiver stalls about half the time
    snd_gap_pct = 10;
    rcv_stall_pct = 52;
    after_word = 1'b0;
    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        if (after_word) drain();
        after_word = 1'b0;
        write_reg(script[i].reg_sel, script[i].x);
      end else begin
        send_word(script[i].mode, script[i].idx, script[i].x, script[i].y,
                  script[i].has_lit, script[i].lit);
        after_word = 1'b1;
      end
    end

    // Random part: two phases per idle pattern, new settings each phase
    for (int ph = 0; ph < RandomPhases; ph++) begin
      case (ph / 2)
        0: begin
          snd_gap_pct = 10;
          rcv_stall_pct = 52;
        end
        1: begin
          snd_gap_pct = 52;
          rcv_stall_pct = 10;
        end
        default: begin
          snd_gap_pct = 0;
          rcv_stall_pct = 0;
        end
      endcase
      drain();
      random_config();
      for (int n = 0; n < WordsPerPhase; n++) begin
        // now and then hold the sender until all results are back
        if (n % 97 == 48 || $urandom_range(199) == 0) begin
          s_axis_tvalid <= 1'b0;
          @(posedge clk);
          while (expected_intensity.size() != 0) @(posedge clk);
        end
        random_word();
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
